/* hdl/pte_pkg.sv */
// ----------------------------------------------------------------------------
// Pigment texel erase package
// Shared widths, constants and beat types of the texel erase pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pte_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MASS_BITS = 16;
  localparam int unsigned FW        = FRAC_BITS + 1;

  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned DIV_STEPS    = FW;
  localparam int unsigned PIPE_LAT     = FRONT_STAGES + DIV_STEPS + 1;

  typedef struct packed {
    logic [MASS_BITS-1:0] mass_before;
    logic [FW-1:0]        erased_so_far;
    logic [FW-1:0]        dab_weight;
    logic [FW-1:0]        strength_cap;
  } pte_in_t;

  typedef struct packed {
    logic [MASS_BITS-1:0] mass_after;
    logic [FW-1:0]        erased_after;
    logic [FW-1:0]        dab_alpha;
    logic                 changed;
  } pte_out_t;

  typedef struct packed {
    logic [MASS_BITS-1:0] mass;
    logic [FW-1:0]        erased_in;
    logic [FW-1:0]        e1;
    logic                 refuse;
  } pte_carry_t;

  typedef struct packed {
    pte_carry_t    carry;
    logic [FW-1:0] headroom;
    logic [FW-1:0] rem;
    logic [FW-1:0] quo;
  } pte_div_t;

endpackage

`default_nettype wire

/* hdl/pte_front.sv */
// ----------------------------------------------------------------------------
// Pigment texel erase front end
// Clamp, refusal test, gain product and new erased fraction in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire pte_pkg::pte_in_t item_i,
  output logic                  valid_o,
  output pte_pkg::pte_div_t     div_o
);
  import pte_pkg::*;

  logic [FW-1:0]        cap_c, e0_c, head_c;
  logic                 refuse_c;

  logic                 a_vld_q;
  logic [MASS_BITS-1:0] a_mass_q;
  logic [FW-1:0]        a_erased_q, a_weight_q, a_cap_q, a_e0_q, a_head_q;
  logic                 a_refuse_q;

  logic [2*FW-1:0]      prod_c;
  logic                 b_vld_q;
  logic [MASS_BITS-1:0] b_mass_q;
  logic [FW-1:0]        b_erased_q, b_cap_q, b_e0_q, b_head_q, b_gain_q;
  logic                 b_refuse_q;

  logic [FW:0]          sum_c;
  logic [FW-1:0]        e1_c;
  logic                 c_vld_q;
  pte_div_t             c_q;

  always_comb begin
    cap_c    = (item_i.strength_cap > ONE) ? ONE : item_i.strength_cap;
    e0_c     = (item_i.erased_so_far > ONE) ? ONE : item_i.erased_so_far;
    head_c   = ONE - e0_c;
    refuse_c = (item_i.dab_weight == '0) || (cap_c == '0) || (head_c == '0) ||
               (e0_c >= cap_c) || (item_i.mass_before == '0);
  end

  always_comb begin
    prod_c = {{FW{1'b0}}, a_weight_q} * {{FW{1'b0}}, a_head_q};
  end

  always_comb begin
    sum_c = {1'b0, b_e0_q} + {1'b0, b_gain_q};
    e1_c  = (sum_c > {1'b0, b_cap_q}) ? b_cap_q : sum_c[FW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mass_q   <= item_i.mass_before;
    a_erased_q <= item_i.erased_so_far;
    a_weight_q <= item_i.dab_weight;
    a_cap_q    <= cap_c;
    a_e0_q     <= e0_c;
    a_head_q   <= head_c;
    a_refuse_q <= refuse_c;

    b_mass_q   <= a_mass_q;
    b_erased_q <= a_erased_q;
    b_cap_q    <= a_cap_q;
    b_e0_q     <= a_e0_q;
    b_head_q   <= a_head_q;
    b_gain_q   <= prod_c[FRAC_BITS +: FW];
    b_refuse_q <= a_refuse_q;

    c_q.carry.mass      <= b_mass_q;
    c_q.carry.erased_in <= b_erased_q;
    c_q.carry.e1        <= e1_c;
    c_q.carry.refuse    <= b_refuse_q;
    c_q.headroom        <= b_head_q;
    c_q.rem             <= e1_c - b_e0_q;
    c_q.quo             <= '0;
  end

  assign valid_o = c_vld_q;
  assign div_o   = c_q;

endmodule

`default_nettype wire

/* hdl/pte_div.sv */
// ----------------------------------------------------------------------------
// Pigment texel erase divider
// Restoring divider, one quotient bit per register stage, for e = diff / headroom.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire pte_pkg::pte_div_t div_i,
  output logic                   valid_o,
  output pte_pkg::pte_div_t      div_o
);
  import pte_pkg::*;

  logic     vld_q [DIV_STEPS];
  pte_div_t stg_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    pte_div_t    src;
    logic        src_vld;
    logic [FW:0] shifted, sub;
    logic        ge;

    if (k == 0) begin : g_first
      assign src     = div_i;
      assign src_vld = valid_i;
      assign shifted = {1'b0, src.rem};
    end else begin : g_next
      assign src     = stg_q[k-1];
      assign src_vld = vld_q[k-1];
      assign shifted = {src.rem, 1'b0};
    end

    assign sub = shifted - {1'b0, src.headroom};
    assign ge  = (shifted >= {1'b0, src.headroom});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[k].carry    <= src.carry;
      stg_q[k].headroom <= src.headroom;
      stg_q[k].rem      <= ge ? sub[FW-1:0] : shifted[FW-1:0];
      stg_q[k].quo      <= src.quo | ({{(FW-1){1'b0}}, ge} << (DIV_STEPS - 1 - k));
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign div_o   = stg_q[DIV_STEPS-1];

endmodule

`default_nettype wire

/* hdl/pte_scale.sv */
// ----------------------------------------------------------------------------
// Pigment texel erase mass scaler
// Limit e to one, scale mass by one minus e unless refused, register the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_scale (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire pte_pkg::pte_div_t div_i,
  output logic                   valid_o,
  output pte_pkg::pte_out_t      result_o
);
  import pte_pkg::*;

  logic [FW-1:0]           e_c, inv_c;
  logic [MASS_BITS+FW-1:0] prod_c;
  pte_out_t                res_d, res_q;
  logic                    vld_q;

  always_comb begin
    e_c    = (div_i.quo > ONE) ? ONE : div_i.quo;
    inv_c  = ONE - e_c;
    prod_c = {{FW{1'b0}}, div_i.carry.mass} * {{MASS_BITS{1'b0}}, inv_c};
    if (div_i.carry.refuse) begin
      res_d.mass_after   = div_i.carry.mass;
      res_d.erased_after = div_i.carry.erased_in;
      res_d.dab_alpha    = '0;
      res_d.changed      = 1'b0;
    end else begin
      res_d.mass_after   = prod_c[FRAC_BITS +: MASS_BITS];
      res_d.erased_after = div_i.carry.e1;
      res_d.dab_alpha    = e_c;
      res_d.changed      = (e_c != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

/* hdl/pigment_texel_erase_unit.sv */
// ----------------------------------------------------------------------------
// Pigment texel erase unit
// One eraser step per texel: new erased fraction, dab alpha and scaled mass.
// ----------------------------------------------------------------------------
// Takes one texel beat per clock cycle; busy is never raised. Each beat's
// result is held on result_o with done_o high for exactly one cycle, and
// results come out in the order the beats were accepted. The pipeline has
// three front stages, one divider stage per quotient bit (17) and the
// output multiply stage. The receiver cannot stall the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pigment_texel_erase_unit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire pte_pkg::pte_in_t item_i,
  output logic                  busy,
  output logic                  done_o,
  output pte_pkg::pte_out_t     result_o
);
  import pte_pkg::*;

  logic     front_vld, div_vld;
  pte_div_t front_div, div_res;

  assign busy = 1'b0;

  pte_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (item_i),
    .valid_o (front_vld),
    .div_o   (front_div)
  );

  pte_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_vld),
    .div_i   (front_div),
    .valid_o (div_vld),
    .div_o   (div_res)
  );

  pte_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_vld),
    .div_i    (div_res),
    .valid_o  (done_o),
    .result_o (result_o)
  );

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT done_o)
    else $error("accepted beat did not complete on time");

  a_alpha_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.dab_alpha <= ONE))
    else $error("dab alpha above one");

  a_changed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.changed == (result_o.dab_alpha != '0)))
    else $error("changed flag disagrees with dab alpha");
`endif

endmodule

`default_nettype wire

/* tb/pigment_texel_erase_unit_tb.sv */
// ----------------------------------------------------------------------------
// Pigment texel erase unit testbench
// Drives texel beats through the erase pipeline in bursts with random gaps.
// Every result is compared field by field against a local model of the
// eraser step. Directed texels cover refusals, clamped fractions and
// truncation to zero. A long random stream follows, broken by a full drain.
// ----------------------------------------------------------------------------
module pigment_texel_erase_unit_tb;
  import pte_pkg::*;

  localparam longint unsigned UNIT      = longint'(1) << FRAC_BITS;
  localparam int              IDLE_LIMIT = 4000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  pte_in_t  item_i;
  logic     busy;
  logic     done_o;
  pte_out_t result_o;

  pte_out_t results_due[$];
  int       texels_sent;
  int       results_checked;
  int       texels_written;
  int       mismatches;
  int       burst_left;
  int       idle_cycles;

  pigment_texel_erase_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic pte_out_t erase_texel(input pte_in_t t);
    longint unsigned mass, weight, cap, e0, room, e1, e, scaled;
    pte_out_t r;
    mass   = t.mass_before;
    weight = t.dab_weight;
    cap    = (t.strength_cap > ONE) ? UNIT : longint'(t.strength_cap);
    e0     = (t.erased_so_far > ONE) ? UNIT : longint'(t.erased_so_far);
    room   = UNIT - e0;
    r.mass_after   = t.mass_before;
    r.erased_after = t.erased_so_far;
    r.dab_alpha    = '0;
    r.changed      = 1'b0;
    if (weight == 0 || cap == 0 || room == 0 || e0 >= cap || mass == 0) return r;
    e1 = e0 + ((weight * room) >> FRAC_BITS);
    if (e1 > cap) e1 = cap;
    e = ((e1 - e0) << FRAC_BITS) / room;
    if (e > UNIT) e = UNIT;
    scaled = (mass * (UNIT - e)) >> FRAC_BITS;
    r.mass_after   = scaled[MASS_BITS-1:0];
    r.erased_after = e1[FW-1:0];
    r.dab_alpha    = e[FW-1:0];
    r.changed      = (e != 0);
    return r;
  endfunction

  function automatic pte_in_t texel(input longint unsigned mass, input longint unsigned erased,
                                    input longint unsigned weight, input longint unsigned cap);
    pte_in_t t;
    t.mass_before   = mass[MASS_BITS-1:0];
    t.erased_so_far = erased[FW-1:0];
    t.dab_weight    = weight[FW-1:0];
    t.strength_cap  = cap[FW-1:0];
    return t;
  endfunction

  function automatic longint unsigned rand_fraction();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return UNIT;
      2:       return UNIT - 1;
      3:       return $urandom_range(1, 16);
      4:       return $urandom_range(UNIT + 1, (UNIT << 1) - 1);
      default: return $urandom_range(0, UNIT);
    endcase
  endfunction

  function automatic longint unsigned rand_mass();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (longint'(1) << MASS_BITS) - 1;
      2:       return $urandom_range(1, 4);
      default: return $urandom_range(0, (1 << MASS_BITS) - 1);
    endcase
  endfunction

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic send_texel(input pte_in_t t);
    bit taken;
    if (burst_left == 0) begin
      hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    start  <= 1'b1;
    item_i <= t;
    do begin
      taken = !busy;
      @(posedge clk_i);
      if (!taken) @(negedge clk_i);
    end while (!taken);
    results_due = {results_due, erase_texel(t)};
    texels_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    pte_out_t want;
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, got 0x%0h", $realtime, result_o);
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (want.changed) texels_written++;
        compare_field("mass_after", want.mass_after, result_o.mass_after);
        compare_field("erased_after", want.erased_after, result_o.erased_after);
        compare_field("dab_alpha", want.dab_alpha, result_o.dab_alpha);
        compare_field("changed", want.changed, result_o.changed);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles with no beat", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_refusals();
    send_texel(texel(0, 0, 0, 0));
    send_texel(texel(1000, 100, 0, UNIT));
    send_texel(texel(1000, 100, UNIT, 0));
    send_texel(texel(1000, UNIT, UNIT, UNIT));
    send_texel(texel(1000, (UNIT << 1) - 1, UNIT, UNIT));
    send_texel(texel(1000, 30000, UNIT, 30000));
    send_texel(texel(1000, 40000, UNIT, 30000));
    send_texel(texel(0, 100, UNIT, UNIT));
  endtask

  task automatic test_edge_fractions();
    send_texel(texel(16'hFFFF, 0, UNIT, UNIT));
    send_texel(texel(16'hFFFF, 0, (UNIT << 1) - 1, UNIT));
    send_texel(texel(16'hFFFF, 0, (UNIT << 1) - 1, (UNIT << 1) - 1));
    send_texel(texel(16'hFFFF, UNIT - 1, UNIT, UNIT));
    send_texel(texel(16'hFFFF, 12345, 1 << 15, 50000));
    send_texel(texel(16'hFFFF, 0, 1, UNIT));
    send_texel(texel(16'h5555, 16'hAAAA, 16'h5555, UNIT + 16'hAAAA));
    send_texel(texel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555 + 16'h2000));
    send_texel(texel(1, 0, UNIT - 1, UNIT - 1));
  endtask

  task automatic test_truncation();
    send_texel(texel(40000, UNIT - 1, UNIT - 1, UNIT));
    send_texel(texel(40000, UNIT - 2, 1, UNIT));
    send_texel(texel(40000, 60000, 3, UNIT));
    send_texel(texel(1, 0, 1, 1));
    send_texel(texel(1, 0, 2, UNIT));
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_texel(texel(rand_mass(), rand_fraction(), rand_fraction(),
                                    rand_fraction()));
  endtask

  task automatic test_drain_and_resume();
    test_random_stream(30);
    wait_drained();
    test_random_stream(30);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    burst_left  = 0;
    texels_sent = 0;
    results_checked = 0;
    texels_written  = 0;
    mismatches  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_refusals();
    test_edge_fractions();
    test_truncation();
    test_random_stream(940);
    test_drain_and_resume();
    test_random_stream(940);
    wait_drained();
    repeat (PIPE_LAT + 8) @(negedge clk_i);
    $display("Sent %0d texel beats, checked %0d results, %0d of them written;",
             texels_sent, results_checked, texels_written);
    $display("refusals, clamped fractions, zero-alpha truncation and a drain pause covered.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
